@@ design/upng_pkg.sv @@
// ----------------------------------------------------------------------------
// upng_pkg
// Shared types, constants and helper functions of the PNG stream encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package upng_pkg;

    localparam int MAX_WIDTH_DEF        = 4096;
    localparam int MAX_HEIGHT_DEF       = 4096;
    localparam int STORED_BLOCK_MAX_DEF = 65535;

    localparam int DIM_W       = 13;
    localparam int DLEN_W      = 28;
    localparam int NUM_W       = DLEN_W + 1;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    localparam logic [31:0] CRC_POLY   = 32'hedb88320;
    localparam logic [31:0] CRC_INIT   = 32'hffffffff;
    localparam logic [16:0] ADLER_MOD  = 17'd65521;
    localparam logic [7:0]  ZLIB_CMF   = 8'h78;
    localparam logic [7:0]  ZLIB_FLG   = 8'h01;
    localparam logic [7:0]  BIT_DEPTH  = 8'd8;
    localparam logic [7:0]  COLOR_RGBA = 8'd6;
    localparam logic [7:0]  IHDR_LEN   = 8'd13;
    localparam logic [31:0] TYPE_IHDR  = 32'h49484452;
    localparam logic [31:0] TYPE_IDAT  = 32'h49444154;
    localparam logic [31:0] TYPE_IEND  = 32'h49454e44;

    localparam logic [7:0] PNG_SIG [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                           8'd13, 8'd10, 8'd26, 8'd10};

    typedef enum logic [1:0] {
        HS_START,
        HS_IMAGE,
        HS_TRAILER
    } hstep_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_BLK,
        PH_DATA,
        PH_TRL
    } phase_t;

    typedef enum logic [1:0] {
        LS_IDLE,
        LS_MUL,
        LS_DIV,
        LS_SUM
    } len_state_t;

    typedef struct packed {
        logic       hdr;
        logic       row_start;
        logic       trailer;
        logic       trailer_only;
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } cmd_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
        logic [7:0] r;
        case (k)
            2'd0:    r = v[31:24];
            2'd1:    r = v[23:16];
            2'd2:    r = v[15:8];
            default: r = v[7:0];
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/upng_front.sv @@
// ----------------------------------------------------------------------------
// upng_front
// Size registers and image position; classifies each pixel into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module upng_front #(
    parameter int MAX_WIDTH  = upng_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = upng_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [31:0]                s_tdata,
    input  wire logic                       cfg_we,
    input  wire logic [0:0]                 cfg_addr,
    input  wire logic [upng_pkg::DIM_W-1:0] cfg_wdata,
    input  wire logic                       q_ready,
    output logic                            q_push,
    output upng_pkg::cmd_t                  q_cmd,
    output logic [upng_pkg::DIM_W-1:0]      width,
    output logic [upng_pkg::DIM_W-1:0]      height
);

    upng_pkg::hstep_t             hstep_reg, hstep_next;
    logic [upng_pkg::DIM_W-1:0]   width_reg, width_next;
    logic [upng_pkg::DIM_W-1:0]   height_reg, height_next;
    logic [upng_pkg::DIM_W-1:0]   col_reg, col_next;
    logic [upng_pkg::DIM_W-1:0]   row_reg, row_next;
    logic [upng_pkg::DIM_W-1:0]   cfg_val;
    logic                         accept;
    logic                         row_end;
    logic                         img_end;

    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;
    assign q_push   = accept;
    assign width    = width_reg;
    assign height   = height_reg;

    assign row_end = ({1'b0, col_reg} + 14'd1) >= {1'b0, width_reg};
    assign img_end = row_end && (({1'b0, row_reg} + 14'd1) >= {1'b0, height_reg});

    always_comb begin
        cfg_val = (cfg_wdata == '0) ? upng_pkg::DIM_W'(1) : cfg_wdata;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we && hstep_reg == upng_pkg::HS_START) begin
            case (cfg_addr)
                upng_pkg::REG_WIDTH: begin
                    width_next = (32'(cfg_val) > MAX_WIDTH) ?
                                 upng_pkg::DIM_W'(MAX_WIDTH) : cfg_val;
                end
                upng_pkg::REG_HEIGHT: begin
                    height_next = (32'(cfg_val) > MAX_HEIGHT) ?
                                  upng_pkg::DIM_W'(MAX_HEIGHT) : cfg_val;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        hstep_next = hstep_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        q_cmd.hdr          = 1'b0;
        q_cmd.row_start    = (col_reg == '0);
        q_cmd.trailer      = 1'b0;
        q_cmd.trailer_only = 1'b0;
        q_cmd.red          = s_tdata[7:0];
        q_cmd.green        = s_tdata[15:8];
        q_cmd.blue         = s_tdata[23:16];
        q_cmd.alpha        = s_tdata[31:24];
        if (hstep_reg == upng_pkg::HS_TRAILER) begin
            q_cmd.trailer_only = 1'b1;
            if (accept) begin
                hstep_next = upng_pkg::HS_START;
            end
        end else begin
            q_cmd.hdr     = (hstep_reg == upng_pkg::HS_START);
            q_cmd.trailer = img_end && hstep_reg != upng_pkg::HS_START;
            if (accept) begin
                hstep_next = upng_pkg::HS_IMAGE;
                col_next   = row_end ? '0 : col_reg + 1'b1;
                if (row_end) begin
                    row_next = img_end ? '0 : row_reg + 1'b1;
                end
                if (img_end) begin
                    hstep_next = (hstep_reg == upng_pkg::HS_START) ?
                                 upng_pkg::HS_TRAILER : upng_pkg::HS_START;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hstep_reg  <= upng_pkg::HS_START;
            width_reg  <= upng_pkg::DIM_W'(1);
            height_reg <= upng_pkg::DIM_W'(1);
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            hstep_reg  <= hstep_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

`default_nettype wire

@@ design/upng_queue.sv @@
// ----------------------------------------------------------------------------
// upng_queue
// Short command queue between the front and the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module upng_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  upng_pkg::cmd_t      push_cmd,
    output logic                ready,
    input  wire logic           pop,
    output logic                valid,
    output upng_pkg::cmd_t      head
);

    localparam int PTR_W = $clog2(upng_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(upng_pkg::QUEUE_DEPTH + 1);

    upng_pkg::cmd_t     mem_reg [upng_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign ready   = cnt_reg != CNT_W'(upng_pkg::QUEUE_DEPTH);
    assign valid   = cnt_reg != '0;
    assign head    = mem_reg[rd_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_next  = do_push ? PTR_W'((32'(wr_reg) + 1) % upng_pkg::QUEUE_DEPTH) : wr_reg;
        rd_next  = do_pop ? PTR_W'((32'(rd_reg) + 1) % upng_pkg::QUEUE_DEPTH) : rd_reg;
        cnt_next = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    property p_count_bound;
        @(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(upng_pkg::QUEUE_DEPTH);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("queue overfilled");

    property p_ptr_gap;
        @(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> (wr_reg == rd_reg);
    endproperty
    a_ptr_gap: assert property (p_ptr_gap) else $error("queue pointers out of step");

    property p_full_block;
        @(posedge aclk) disable iff (!aresetn)
        !ready |=> (cnt_reg != '0);
    endproperty
    a_full_block: assert property (p_full_block) else $error("queue lost items");

endmodule

`default_nettype wire

@@ design/upng_len.sv @@
// ----------------------------------------------------------------------------
// upng_len
// Filtered data length and IDAT length: one multiply, then a ceiling
// division by the stored block size through a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module upng_len #(
    parameter int STORED_BLOCK_MAX = upng_pkg::STORED_BLOCK_MAX_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [upng_pkg::DIM_W-1:0]  width,
    input  wire logic [upng_pkg::DIM_W-1:0]  height,
    output logic                             done,
    output logic [upng_pkg::DLEN_W-1:0]      data_len,
    output logic [31:0]                      idat_len
);

    localparam int NUM_W  = upng_pkg::NUM_W;
    localparam int DIV_SH = NUM_W + $clog2(STORED_BLOCK_MAX);
    localparam int RCP_W  = NUM_W + 1;
    localparam int PROD_W = NUM_W + RCP_W;
    // ceil(2^DIV_SH / STORED_BLOCK_MAX): exact quotient for any NUM_W-bit numerator
    localparam logic [63:0] RCP_FULL = ((64'd1 << DIV_SH) + 64'(STORED_BLOCK_MAX) - 64'd1) /
                                       64'(STORED_BLOCK_MAX);
    localparam logic [RCP_W-1:0] RCP = RCP_FULL[RCP_W-1:0];

    upng_pkg::len_state_t          state_reg, state_next;
    logic                          done_reg, done_next;
    logic [upng_pkg::DLEN_W-1:0]   dl_reg, dl_next;
    logic [NUM_W-1:0]              num_reg, num_next;
    logic [NUM_W-1:0]              quo_reg, quo_next;
    logic [31:0]                   idat_reg, idat_next;
    logic [upng_pkg::DLEN_W-1:0]   dl_prod;
    logic [PROD_W-1:0]             prod;

    assign done     = done_reg;
    assign data_len = dl_reg;
    assign idat_len = idat_reg;

    assign dl_prod = upng_pkg::DLEN_W'(height) * upng_pkg::DLEN_W'({width, 2'b01});
    assign prod    = PROD_W'(num_reg) * PROD_W'(RCP);

    always_comb begin
        state_next = state_reg;
        done_next  = done_reg;
        dl_next    = dl_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        idat_next  = idat_reg;
        case (state_reg)
            upng_pkg::LS_IDLE: begin
                if (start) begin
                    state_next = upng_pkg::LS_MUL;
                    done_next  = 1'b0;
                end
            end
            upng_pkg::LS_MUL: begin
                dl_next    = dl_prod;
                state_next = upng_pkg::LS_DIV;
                num_next   = NUM_W'(dl_prod) + NUM_W'(STORED_BLOCK_MAX - 1);
            end
            upng_pkg::LS_DIV: begin
                quo_next   = NUM_W'(prod >> DIV_SH);
                state_next = upng_pkg::LS_SUM;
            end
            upng_pkg::LS_SUM: begin
                idat_next  = 32'd6 + 32'(dl_reg) + 32'(quo_reg) + (32'(quo_reg) << 2);
                done_next  = 1'b1;
                state_next = upng_pkg::LS_IDLE;
            end
            default: state_next = upng_pkg::LS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        dl_reg   <= dl_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        idat_reg <= idat_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= upng_pkg::LS_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

endmodule

`default_nettype wire

@@ design/upng_back.sv @@
// ----------------------------------------------------------------------------
// upng_back
// Byte sequencer: header, stored block headers, data, trailer; running
// CRC-32 and Adler-32; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module upng_back #(
    parameter int STORED_BLOCK_MAX = upng_pkg::STORED_BLOCK_MAX_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        q_valid,
    input  upng_pkg::cmd_t                   q_head,
    output logic                             q_pop,
    input  wire logic [upng_pkg::DIM_W-1:0]  width,
    input  wire logic [upng_pkg::DIM_W-1:0]  height,
    output logic                             len_start,
    input  wire logic                        len_done,
    input  wire logic [upng_pkg::DLEN_W-1:0] data_len,
    input  wire logic [31:0]                 idat_len,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [7:0]                       m_tdata,
    output logic                             m_tlast,
    output logic                             m_tuser
);

    localparam logic [5:0] HDR_LAST = 6'd42;
    localparam logic [5:0] BLK_LAST = 6'd4;
    localparam logic [5:0] TRL_LAST = 6'd19;
    localparam logic [2:0] SLOT_LAST = 3'd4;

    upng_pkg::phase_t             phase_reg, phase_next;
    upng_pkg::cmd_t               cmd_reg, cmd_next;
    logic [5:0]                   idx_reg, idx_next;
    logic [2:0]                   slot_reg, slot_next;
    logic [31:0]                  crc_reg, crc_next;
    logic [15:0]                  adl_lo_reg, adl_lo_next;
    logic [15:0]                  adl_hi_reg, adl_hi_next;
    logic [upng_pkg::DLEN_W-1:0]  left_reg, left_next;
    logic [15:0]                  fill_reg, fill_next;
    logic                         m_valid_reg, m_valid_next;
    logic [7:0]                   m_byte_reg, m_byte_next;
    logic                         m_last_reg, m_last_next;
    logic                         m_eof_reg, m_eof_next;

    logic        adv;
    logic        emit;
    logic [7:0]  byte_val;
    logic        crc_en;
    logic        crc_init;
    logic        lor;
    logic        eof;
    logic [31:0] crc_base;
    logic        small_left;
    logic [15:0] blk_size;
    logic [15:0] blk_inv;
    logic [16:0] lo_sum;
    logic [15:0] lo_mod;
    logic [16:0] hi_sum;
    logic [15:0] hi_mod;
    logic [15:0] fill_dec;
    logic [7:0]  pix_byte;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_eof_reg;

    assign adv = !m_valid_reg || m_tready;

    assign small_left = left_reg <= upng_pkg::DLEN_W'(STORED_BLOCK_MAX);
    assign blk_size   = small_left ? left_reg[15:0] : 16'(STORED_BLOCK_MAX);
    assign blk_inv    = ~blk_size;

    assign lo_sum = {1'b0, adl_lo_reg} + {9'd0, byte_val};
    assign lo_mod = (lo_sum >= upng_pkg::ADLER_MOD) ?
                    16'(lo_sum - upng_pkg::ADLER_MOD) : lo_sum[15:0];
    assign hi_sum = {1'b0, adl_hi_reg} + {1'b0, lo_mod};
    assign hi_mod = (hi_sum >= upng_pkg::ADLER_MOD) ?
                    16'(hi_sum - upng_pkg::ADLER_MOD) : hi_sum[15:0];
    assign fill_dec = (fill_reg != '0) ? fill_reg - 1'b1 : fill_reg;

    always_comb begin
        case (slot_reg)
            3'd1:    pix_byte = cmd_reg.red;
            3'd2:    pix_byte = cmd_reg.green;
            3'd3:    pix_byte = cmd_reg.blue;
            3'd4:    pix_byte = cmd_reg.alpha;
            default: pix_byte = 8'd0;
        endcase
    end

    always_comb begin
        byte_val = 8'd0;
        crc_en   = 1'b0;
        crc_init = 1'b0;
        case (phase_reg)
            upng_pkg::PH_HDR: begin
                crc_en   = (idx_reg inside {[6'd12:6'd28], [6'd37:6'd42]});
                crc_init = (idx_reg == 6'd12) || (idx_reg == 6'd37);
                if (idx_reg inside {[6'd0:6'd7]}) begin
                    byte_val = upng_pkg::PNG_SIG[idx_reg[2:0]];
                end else if (idx_reg == 6'd11) begin
                    byte_val = upng_pkg::IHDR_LEN;
                end else if (idx_reg inside {[6'd12:6'd15]}) begin
                    byte_val = upng_pkg::be_byte(upng_pkg::TYPE_IHDR, idx_reg[1:0]);
                end else if (idx_reg inside {[6'd16:6'd19]}) begin
                    byte_val = upng_pkg::be_byte(32'(width), idx_reg[1:0]);
                end else if (idx_reg inside {[6'd20:6'd23]}) begin
                    byte_val = upng_pkg::be_byte(32'(height), idx_reg[1:0]);
                end else if (idx_reg == 6'd24) begin
                    byte_val = upng_pkg::BIT_DEPTH;
                end else if (idx_reg == 6'd25) begin
                    byte_val = upng_pkg::COLOR_RGBA;
                end else if (idx_reg inside {[6'd29:6'd32]}) begin
                    byte_val = upng_pkg::be_byte(~crc_reg, 2'(idx_reg - 6'd29));
                end else if (idx_reg inside {[6'd33:6'd36]}) begin
                    byte_val = upng_pkg::be_byte(idat_len, 2'(idx_reg - 6'd33));
                end else if (idx_reg inside {[6'd37:6'd40]}) begin
                    byte_val = upng_pkg::be_byte(upng_pkg::TYPE_IDAT, 2'(idx_reg - 6'd37));
                end else if (idx_reg == 6'd41) begin
                    byte_val = upng_pkg::ZLIB_CMF;
                end else if (idx_reg == 6'd42) begin
                    byte_val = upng_pkg::ZLIB_FLG;
                end
            end
            upng_pkg::PH_BLK: begin
                crc_en = 1'b1;
                case (idx_reg)
                    6'd0:    byte_val = {7'd0, small_left};
                    6'd1:    byte_val = blk_size[7:0];
                    6'd2:    byte_val = blk_size[15:8];
                    6'd3:    byte_val = blk_inv[7:0];
                    default: byte_val = blk_inv[15:8];
                endcase
            end
            upng_pkg::PH_DATA: begin
                crc_en   = 1'b1;
                byte_val = pix_byte;
            end
            upng_pkg::PH_TRL: begin
                crc_en   = (idx_reg inside {[6'd0:6'd3], [6'd12:6'd15]});
                crc_init = (idx_reg == 6'd12);
                if (idx_reg inside {[6'd0:6'd3]}) begin
                    byte_val = upng_pkg::be_byte({adl_hi_reg, adl_lo_reg}, idx_reg[1:0]);
                end else if (idx_reg inside {[6'd4:6'd7], [6'd16:6'd19]}) begin
                    byte_val = upng_pkg::be_byte(~crc_reg, idx_reg[1:0]);
                end else if (idx_reg inside {[6'd12:6'd15]}) begin
                    byte_val = upng_pkg::be_byte(upng_pkg::TYPE_IEND, idx_reg[1:0]);
                end
            end
            default: ;
        endcase
    end

    assign emit = adv && (phase_reg != upng_pkg::PH_IDLE) &&
                  !(phase_reg == upng_pkg::PH_HDR && !len_done &&
                    (idx_reg inside {[6'd33:6'd36]}));
    assign crc_base = crc_init ? upng_pkg::CRC_INIT : crc_reg;

    always_comb begin
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        idx_next    = idx_reg;
        slot_next   = slot_reg;
        crc_next    = crc_reg;
        adl_lo_next = adl_lo_reg;
        adl_hi_next = adl_hi_reg;
        left_next   = left_reg;
        fill_next   = fill_reg;
        q_pop       = 1'b0;
        len_start   = 1'b0;
        lor         = 1'b0;
        eof         = 1'b0;
        if (emit && crc_en) begin
            crc_next = upng_pkg::crc_byte(crc_base, byte_val);
        end
        case (phase_reg)
            upng_pkg::PH_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    cmd_next  = q_head;
                    idx_next  = '0;
                    slot_next = q_head.row_start ? 3'd0 : 3'd1;
                    if (q_head.trailer_only) begin
                        phase_next = upng_pkg::PH_TRL;
                    end else if (q_head.hdr) begin
                        phase_next = upng_pkg::PH_HDR;
                        len_start  = 1'b1;
                    end else begin
                        phase_next = (fill_reg == '0) ? upng_pkg::PH_BLK : upng_pkg::PH_DATA;
                    end
                end
            end
            upng_pkg::PH_HDR: begin
                if (emit) begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == HDR_LAST) begin
                        idx_next    = '0;
                        left_next   = data_len;
                        fill_next   = '0;
                        adl_lo_next = 16'd1;
                        adl_hi_next = 16'd0;
                        phase_next  = upng_pkg::PH_BLK;
                    end
                end
            end
            upng_pkg::PH_BLK: begin
                if (emit) begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == BLK_LAST) begin
                        idx_next   = '0;
                        fill_next  = blk_size;
                        phase_next = upng_pkg::PH_DATA;
                    end
                end
            end
            upng_pkg::PH_DATA: begin
                if (emit) begin
                    adl_lo_next = lo_mod;
                    adl_hi_next = hi_mod;
                    fill_next   = fill_dec;
                    left_next   = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
                    idx_next    = '0;
                    if (slot_reg == SLOT_LAST) begin
                        if (cmd_reg.trailer) begin
                            phase_next = upng_pkg::PH_TRL;
                        end else begin
                            phase_next = upng_pkg::PH_IDLE;
                            lor        = 1'b1;
                        end
                    end else begin
                        slot_next  = slot_reg + 1'b1;
                        phase_next = (fill_dec == '0) ? upng_pkg::PH_BLK : upng_pkg::PH_DATA;
                    end
                end
            end
            upng_pkg::PH_TRL: begin
                if (emit) begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == TRL_LAST) begin
                        idx_next   = '0;
                        phase_next = upng_pkg::PH_IDLE;
                        lor        = 1'b1;
                        eof        = 1'b1;
                    end
                end
            end
            default: phase_next = upng_pkg::PH_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        m_eof_next   = m_eof_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_byte_next  = byte_val;
            m_last_next  = lor;
            m_eof_next   = eof;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        slot_reg   <= slot_next;
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
        m_eof_reg  <= m_eof_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= upng_pkg::PH_IDLE;
            idx_reg     <= '0;
            crc_reg     <= upng_pkg::CRC_INIT;
            adl_lo_reg  <= 16'd1;
            adl_hi_reg  <= 16'd0;
            left_reg    <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            idx_reg     <= idx_next;
            crc_reg     <= crc_next;
            adl_lo_reg  <= adl_lo_next;
            adl_hi_reg  <= adl_hi_next;
            left_reg    <= left_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    property p_eof_last;
        @(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_eof_reg) |-> m_last_reg;
    endproperty
    a_eof_last: assert property (p_eof_last) else $error("end of file without last flag");

    property p_data_in_block;
        @(posedge aclk) disable iff (!aresetn)
        (phase_reg == upng_pkg::PH_DATA) |-> (fill_reg != '0);
    endproperty
    a_data_in_block: assert property (p_data_in_block) else $error("data outside block");

    property p_trailer_drained;
        @(posedge aclk) disable iff (!aresetn)
        (phase_reg == upng_pkg::PH_TRL && cmd_reg.hdr == 1'b0) |->
            (left_reg == '0 && fill_reg == '0);
    endproperty
    a_trailer_drained: assert property (p_trailer_drained) else $error("trailer before data end");

endmodule

`default_nettype wire

@@ design/uncompressed_png_stream_encoder_core.sv @@
// ----------------------------------------------------------------------------
// uncompressed_png_stream_encoder_core
// RGBA8 pixels in, bytes of a complete uncompressed PNG file out.
// ----------------------------------------------------------------------------
// Output is one byte per cycle while m_tready is high and no command is
// being fetched; a pixel gives 4 or 5 data bytes, 5 more at each stored
// block header; the first pixel of a file 53 bytes and the last 20 more.
// Pixel accept to first byte, empty queue: queue, command and output registers.
// The IDAT length unit runs its multiply, divide and sum states behind the header.
// Synchronous active-low reset; sizes reset to 1x1.
`default_nettype none

module uncompressed_png_stream_encoder_core #(
    parameter int MAX_WIDTH        = upng_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT       = upng_pkg::MAX_HEIGHT_DEF,
    parameter int STORED_BLOCK_MAX = upng_pkg::STORED_BLOCK_MAX_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [31:0]                s_tdata,   // red, green, blue, alpha
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [7:0]                      m_tdata,   // out_byte
    output logic                            m_tlast,
    output logic                            m_tuser,   // end_of_file
    input  wire logic                       cfg_we,
    input  wire logic [0:0]                 cfg_addr,
    input  wire logic [upng_pkg::DIM_W-1:0] cfg_wdata
);

    upng_pkg::cmd_t               push_cmd;
    upng_pkg::cmd_t               head_cmd;
    logic                         q_push;
    logic                         q_ready;
    logic                         q_valid;
    logic                         q_pop;
    logic [upng_pkg::DIM_W-1:0]   width;
    logic [upng_pkg::DIM_W-1:0]   height;
    logic                         len_start;
    logic                         len_done;
    logic [upng_pkg::DLEN_W-1:0]  data_len;
    logic [31:0]                  idat_len;

    upng_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_cmd     (push_cmd),
        .width     (width),
        .height    (height)
    );

    upng_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .ready    (q_ready),
        .pop      (q_pop),
        .valid    (q_valid),
        .head     (head_cmd)
    );

    upng_len #(
        .STORED_BLOCK_MAX (STORED_BLOCK_MAX)
    ) u_len (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (len_start),
        .width    (width),
        .height   (height),
        .done     (len_done),
        .data_len (data_len),
        .idat_len (idat_len)
    );

    upng_back #(
        .STORED_BLOCK_MAX (STORED_BLOCK_MAX)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_head    (head_cmd),
        .q_pop     (q_pop),
        .width     (width),
        .height    (height),
        .len_start (len_start),
        .len_done  (len_done),
        .data_len  (data_len),
        .idat_len  (idat_len),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

@@ tb/tb_uncompressed_png_stream_encoder_core.sv @@
// ----------------------------------------------------------------------------
// tb_uncompressed_png_stream_encoder_core
// Streams RGBA pixels through the PNG encoder over several image sizes and
// checks every output byte, tlast and end-of-file flag against a predicted
// PNG byte stream built alongside the stimulus.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_uncompressed_png_stream_encoder_core;
    import upng_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       eof;
    } png_byte_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [7:0]           m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_we = 1'b0;
    logic [0:0]           cfg_addr = REG_WIDTH;
    logic [DIM_W-1:0]     cfg_wdata = '0;

    // predictor state
    int unsigned img_w, img_h, col, row, blk_left, data_left, crc, ad_lo, ad_hi;
    hstep_t      file_step;
    png_byte_t   exp_bytes[$];
    png_byte_t   step_bytes[$];

    int errors = 0;
    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int hold_cycles = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    uncompressed_png_stream_encoder_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    function automatic void put(input int unsigned b);
        png_byte_t e;
        e.data = b[7:0];
        e.last = 1'b0;
        e.eof  = 1'b0;
        step_bytes.insert(step_bytes.size(), e);
    endfunction

    function automatic void put_crc(input int unsigned b);
        crc = crc ^ (b & 8'hff);
        for (int i = 0; i < 8; i++)
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        put(b);
    endfunction

    function automatic void put_word(input int unsigned v, input bit with_crc);
        for (int s = 24; s >= 0; s -= 8)
            if (with_crc) put_crc(v >> s); else put(v >> s);
    endfunction

    function automatic void open_chunk(input int unsigned len, input logic [31:0] kind);
        put_word(len, 0);
        crc = CRC_INIT;
        put_word(kind, 1);
    endfunction

    function automatic void put_image_byte(input int unsigned b);
        int unsigned sz, inv;
        if (blk_left == 0) begin
            sz  = data_left < STORED_BLOCK_MAX_DEF ? data_left : STORED_BLOCK_MAX_DEF;
            inv = ~sz & 16'hffff;
            put_crc(sz == data_left ? 1 : 0);
            put_crc(sz & 8'hff);
            put_crc(sz >> 8);
            put_crc(inv & 8'hff);
            put_crc(inv >> 8);
            blk_left = sz;
        end
        put_crc(b);
        ad_lo = (ad_lo + (b & 8'hff)) % ADLER_MOD;
        ad_hi = (ad_hi + ad_lo) % ADLER_MOD;
        if (blk_left > 0) blk_left--;
        if (data_left > 0) data_left--;
    endfunction

    function automatic void put_file_head();
        int unsigned dlen, nblk;
        dlen = img_h * (img_w * 4 + 1);
        nblk = (dlen + STORED_BLOCK_MAX_DEF - 1) / STORED_BLOCK_MAX_DEF;
        for (int i = 0; i < 8; i++) put(PNG_SIG[i]);
        open_chunk(IHDR_LEN, TYPE_IHDR);
        put_word(img_w, 1);
        put_word(img_h, 1);
        put_crc(BIT_DEPTH);
        put_crc(COLOR_RGBA);
        put_crc(0); put_crc(0); put_crc(0);
        put_word(~crc, 0);
        open_chunk(2 + dlen + 5 * nblk + 4, TYPE_IDAT);
        put_crc(ZLIB_CMF);
        put_crc(ZLIB_FLG);
        ad_lo = 1; ad_hi = 0;
        data_left = dlen;
        blk_left = 0; col = 0; row = 0;
    endfunction

    function automatic void put_file_tail();
        put_word((ad_hi << 16) | ad_lo, 1);
        put_word(~crc, 0);
        open_chunk(0, TYPE_IEND);
        put_word(~crc, 0);
        step_bytes[$].eof = 1'b1;
    endfunction

    function automatic void predict_pixel(input logic [31:0] px);
        bit first_px = 0;
        step_bytes.delete();
        if (file_step == HS_TRAILER) begin
            put_file_tail();
            file_step = HS_START;
        end else begin
            if (file_step == HS_START) begin
                put_file_head();
                file_step = HS_IMAGE;
                first_px = 1;
            end
            if (col == 0) put_image_byte(0);
            for (int i = 0; i < 4; i++) put_image_byte(px[8*i +: 8]);
            col++;
            if (col >= img_w) begin
                col = 0;
                row++;
                if (row >= img_h) begin
                    row = 0;
                    if (first_px) file_step = HS_TRAILER;
                    else begin
                        put_file_tail();
                        file_step = HS_START;
                    end
                end
            end
        end
        step_bytes[$].last = 1'b1;
        foreach (step_bytes[i]) exp_bytes.insert(exp_bytes.size(), step_bytes[i]);
    endfunction

    task automatic send_pixel(input logic [31:0] px);
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        predict_pixel(px);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (exp_bytes.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input int unsigned v);
        int unsigned s;
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v[DIM_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (file_step == HS_START) begin
            s = v & 16'h1fff;
            if (s < 1) s = 1;
            if (idx == REG_WIDTH) img_w = s > MAX_WIDTH_DEF ? MAX_WIDTH_DEF : s;
            else img_h = s > MAX_HEIGHT_DEF ? MAX_HEIGHT_DEF : s;
        end
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_px();
        case ($urandom_range(5))
            0: rand_px = 32'h0;
            1: rand_px = 32'hffffffff;
            default: rand_px = $urandom;
        endcase
    endfunction

    // whole images of a given size
    task automatic send_image(input int unsigned w, input int unsigned h);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        for (int i = 0; i < img_w * img_h; i++) send_pixel(rand_px());
        if (img_w * img_h == 1) send_pixel($urandom);
        wait_drained();
    endtask

    task automatic test_directed();
        send_pixel(32'h00000000);
        send_pixel(32'hcafe1234);
        wait_drained();
        write_reg(REG_WIDTH, 2);
        write_reg(REG_HEIGHT, 2);
        send_pixel(32'hffffffff);
        wait_drained();
        // mid-file writes are ignored
        write_reg(REG_WIDTH, 3);
        write_reg(REG_HEIGHT, 3);
        for (int i = 0; i < 3; i++) send_pixel(32'h55aa00ff ^ i);
        wait_drained();
    endtask

    // oversize and zero sizes saturate; header and first 8 pixels of the first row only
    task automatic test_size_limits();
        write_reg(REG_WIDTH, 13'h1fff);
        write_reg(REG_HEIGHT, 0);
        for (int i = 0; i < 8; i++) send_pixel(rand_px());
        wait_drained();
    endtask

    task automatic test_random_sizes(input int n_px);
        int sent = 0;
        while (sent < n_px) begin
            send_image($urandom_range(1, 9), $urandom_range(1, 6));
            sent += img_w * img_h;
        end
    endtask

    task automatic test_backpressure();
        write_reg(REG_WIDTH, 5);
        write_reg(REG_HEIGHT, 4);
        fork
            hold_cycles = 400;
            for (int i = 0; i < 20; i++) send_pixel($urandom);
        join
        wait_drained();
    endtask

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !(dst_idle_pct > 0 && $urandom_range(99) < dst_idle_pct);
        end
    end

    always @(posedge aclk) begin
        png_byte_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (exp_bytes.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected byte %h", m_tdata);
            end else begin
                e = exp_bytes.pop_front();
                if (e.data !== m_tdata || e.last !== m_tlast || e.eof !== m_tuser) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %h/%b/%b got %h/%b/%b", e.data, e.last,
                                 e.eof, m_tdata, m_tlast, m_tuser);
                end
            end
        end
    end

    initial begin
        img_w = 1; img_h = 1; col = 0; row = 0; blk_left = 0; data_left = 0;
        crc = CRC_INIT; ad_lo = 1; ad_hi = 0; file_step = HS_START;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        src_idle_pct = 17; dst_idle_pct = 53;
        test_directed();
        test_backpressure();
        test_random_sizes(130);
        src_idle_pct = 53; dst_idle_pct = 17;
        test_random_sizes(130);
        src_idle_pct = 0; dst_idle_pct = 0;
        test_random_sizes(130);
        test_size_limits();
        repeat (50) @(posedge aclk);
        if (exp_bytes.size() != 0) errors++;
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
